// File: sv/prefill_cost_estimator_macros.svh
// assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef PREFILL_COST_ESTIMATOR_MACROS_SVH
`define PREFILL_COST_ESTIMATOR_MACROS_SVH

// plain property
`define PCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// overlapping implication
`define PCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pce_pkg.sv
`timescale 1ns / 1ps

package pce_pkg;

  localparam int unsigned CostW   = 64;
  localparam int unsigned CountW  = 32;
  localparam int unsigned PairW   = 64;
  localparam int unsigned EstW    = 64;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgChunkCost = 3'd0,
    CfgTokenCost = 3'd1,
    CfgPairCost  = 3'd2,
    CfgImageCost = 3'd3,
    CfgPatchCost = 3'd4
  } cfg_idx_e;

  typedef logic [CostW-1:0]  cost_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [PairW-1:0]  pair_t;
  typedef logic [EstW-1:0]   est_t;

endpackage

// File: sv/pce_if.sv
`timescale 1ns / 1ps

interface pce_work_if;
  import pce_pkg::*;

  logic   valid;
  logic   ready;
  count_t chunk_count;
  count_t token_count;
  pair_t  pair_count;
  count_t image_count;
  count_t patch_count;

  modport source (
    output valid, chunk_count, token_count, pair_count, image_count, patch_count,
    input  ready
  );
  modport sink (
    input  valid, chunk_count, token_count, pair_count, image_count, patch_count,
    output ready
  );
endinterface

interface pce_est_if;
  import pce_pkg::*;

  logic valid;
  logic ready;
  est_t estimate_ns;

  modport source (output valid, estimate_ns, input ready);
  modport sink (input valid, estimate_ns, output ready);
endinterface

// File: sv/prefill_cost_estimator.sv
// Prefill cost estimator: each work item gives one estimate in nanoseconds, the saturating
// sum of chunks * chunk_cost, ceil(tokens * token_cost_q32 / 2^32),
// ceil(pairs * pair_cost_q32 / 2^32), images * image_item_cost and
// ceil(patches * patch_cost_q32 / 2^32), all ones on any overflow. The datapath is a
// five-stage pipeline (input register, twelve 32x32 partial products, per-term
// rounding and saturation, partial sums, final saturating sum in the output
// register), and one item can be taken every cycle while the output is not stalled. Ready
// passes back combinationally through all stages, so an empty stage fills while the output
// waits. Coefficients reset to zero and are written through the cfg port; the user must
// write them only while no item is in flight, as the block does not enforce it.
`timescale 1ns / 1ps

module prefill_cost_estimator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pce_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pce_pkg::CostW-1:0]    cfg_wdata_i,
  pce_work_if.sink                     work_i,
  pce_est_if.source                    est_o
);
  import pce_pkg::*;

  typedef struct packed {
    count_t chunk_count;
    count_t token_count;
    pair_t  pair_count;
    count_t image_count;
    count_t patch_count;
  } work_t;

  typedef struct packed {
    logic [63:0] chunk_lo;
    logic [63:0] chunk_hi;
    logic [63:0] token_lo;
    logic [63:0] token_hi;
    logic [63:0] pair_ll;
    logic [63:0] pair_lh;
    logic [63:0] pair_hl;
    logic [63:0] pair_hh;
    logic [63:0] image_lo;
    logic [63:0] image_hi;
    logic [63:0] patch_lo;
    logic [63:0] patch_hi;
  } prod_t;

  typedef struct packed {
    est_t chunk;
    est_t token;
    est_t pair;
    est_t image;
    est_t patch;
  } term_t;

  typedef struct packed {
    logic [EstW+1:0] sum_a;
    logic [EstW:0]   sum_b;
  } part_t;

  function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p;
  endfunction

  // integer product from hi/lo partials, saturated
  function automatic est_t int_term(input logic [63:0] lo, input logic [63:0] hi);
    logic [64:0] s;
    s = {1'b0, hi} + {33'd0, lo[63:32]};
    return (|s[64:32]) ? '1 : {s[31:0], lo[31:0]};
  endfunction

  // ceil of q32.32 product with a 32-bit count, saturated
  function automatic est_t q32_term(input logic [63:0] lo, input logic [63:0] hi);
    logic [64:0] s;
    s = {1'b0, hi} + {33'd0, lo[63:32]} + {64'd0, |lo[31:0]};
    return s[64] ? '1 : s[63:0];
  endfunction

  // ceil of q32.32 product with a 64-bit count, saturated
  function automatic est_t pair_term(input prod_t p);
    logic [65:0] s;
    s = {2'd0, p.pair_lh} + {2'd0, p.pair_hl}
      + {34'd0, p.pair_ll[63:32]} + {65'd0, |p.pair_ll[31:0]}
      + {2'd0, p.pair_hh[31:0], 32'd0};
    return ((|p.pair_hh[63:32]) || (|s[65:64])) ? '1 : s[63:0];
  endfunction

  cost_t chunk_cost_q, token_cost_q, pair_cost_q, image_cost_q, patch_cost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_cost_q <= '0;
      token_cost_q <= '0;
      pair_cost_q  <= '0;
      image_cost_q <= '0;
      patch_cost_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgChunkCost: chunk_cost_q <= cfg_wdata_i;
        CfgTokenCost: token_cost_q <= cfg_wdata_i;
        CfgPairCost:  pair_cost_q  <= cfg_wdata_i;
        CfgImageCost: image_cost_q <= cfg_wdata_i;
        CfgPatchCost: patch_cost_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic v1_d, v2_d, v3_d, v4_d, v5_d;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic in_acc;

  assign rdy5   = !v5_q || est_o.ready;
  assign rdy4   = !v4_q || rdy5;
  assign rdy3   = !v3_q || rdy4;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign in_acc = work_i.valid && rdy1;

  assign v1_d = rdy1 ? work_i.valid : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;
  assign v4_d = rdy4 ? v3_q : v4_q;
  assign v5_d = rdy5 ? v4_q : v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
      v5_q <= v5_d;
    end
  end

  // datapath
  work_t s1_q, s1_d;
  prod_t prod_q, prod_d;
  term_t term_q, term_d;
  part_t part_q, part_d;
  est_t  est_q, est_d;
  logic [EstW+2:0] total;

  assign s1_d = '{chunk_count: work_i.chunk_count, token_count: work_i.token_count,
                  pair_count: work_i.pair_count, image_count: work_i.image_count,
                  patch_count: work_i.patch_count};

  always_comb begin
    prod_d.chunk_lo = mul32(chunk_cost_q[31:0],  s1_q.chunk_count);
    prod_d.chunk_hi = mul32(chunk_cost_q[63:32], s1_q.chunk_count);
    prod_d.token_lo = mul32(token_cost_q[31:0],  s1_q.token_count);
    prod_d.token_hi = mul32(token_cost_q[63:32], s1_q.token_count);
    prod_d.pair_ll  = mul32(pair_cost_q[31:0],   s1_q.pair_count[31:0]);
    prod_d.pair_lh  = mul32(pair_cost_q[31:0],   s1_q.pair_count[63:32]);
    prod_d.pair_hl  = mul32(pair_cost_q[63:32],  s1_q.pair_count[31:0]);
    prod_d.pair_hh  = mul32(pair_cost_q[63:32],  s1_q.pair_count[63:32]);
    prod_d.image_lo = mul32(image_cost_q[31:0],  s1_q.image_count);
    prod_d.image_hi = mul32(image_cost_q[63:32], s1_q.image_count);
    prod_d.patch_lo = mul32(patch_cost_q[31:0],  s1_q.patch_count);
    prod_d.patch_hi = mul32(patch_cost_q[63:32], s1_q.patch_count);
  end

  always_comb begin
    term_d.chunk = int_term(prod_q.chunk_lo, prod_q.chunk_hi);
    term_d.token = q32_term(prod_q.token_lo, prod_q.token_hi);
    term_d.pair  = pair_term(prod_q);
    term_d.image = int_term(prod_q.image_lo, prod_q.image_hi);
    term_d.patch = q32_term(prod_q.patch_lo, prod_q.patch_hi);
  end

  assign part_d.sum_a = {2'd0, term_q.chunk} + {2'd0, term_q.token} + {2'd0, term_q.pair};
  assign part_d.sum_b = {1'b0, term_q.image} + {1'b0, term_q.patch};

  assign total = {1'b0, part_q.sum_a} + {2'd0, part_q.sum_b};
  assign est_d = (|total[EstW+2:EstW]) ? '1 : total[EstW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (rdy2 && v1_q) begin
      prod_q <= prod_d;
    end
    if (rdy3 && v2_q) begin
      term_q <= term_d;
    end
    if (rdy4 && v3_q) begin
      part_q <= part_d;
    end
    if (rdy5 && v4_q) begin
      est_q <= est_d;
    end
  end

  assign work_i.ready      = rdy1;
  assign est_o.valid       = v5_q;
  assign est_o.estimate_ns = est_q;

endmodule

// File: sv/pce_checker.sv
`timescale 1ns / 1ps
`include "prefill_cost_estimator_macros.svh"

module pce_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [pce_pkg::EstW-1:0] estimate_ns_i
);
  import pce_pkg::*;

  // a waiting estimate stays put
  `PCE_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(estimate_ns_i), "estimate changed while stalled")

  // input stalls only behind a blocked output
  `PCE_ASSERT_IMP(a_stall_cause, !in_ready_i, out_valid_i && !out_ready_i, "input stalled without output backpressure")

  // with the output kept ready, an accepted item reaches the output once it has passed every pipeline register
  `PCE_ASSERT_NXT(a_latency, in_valid_i && in_ready_i && out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_i, "item did not reach the output in time")

endmodule

bind prefill_cost_estimator pce_checker u_pce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (work_i.valid),
  .in_ready_i    (work_i.ready),
  .out_valid_i   (est_o.valid),
  .out_ready_i   (est_o.ready),
  .estimate_ns_i (est_o.estimate_ns)
);
